// ===== hdl/zrle_pkg.sv =====
// Shared types and constants for the zero-run RLE encoder.
// Holds the command and result beat layouts and the header op codes.
// No dependencies.
`timescale 1ns / 1ps

package zrle_pkg;

	localparam int LITERAL_CHUNK_MAX = 32;
	localparam int CMD_FIFO_DEPTH    = 2;
	localparam int RES_FIFO_DEPTH    = 4;

	localparam logic [4:0]  MIN_RUN_RESET = 5'd8;
	localparam logic [4:0]  MIN_RUN_CEIL  = 5'd16;
	localparam logic [7:0]  OP_LITERAL    = 8'd0;
	localparam logic [7:0]  OP_ZERO_RUN   = 8'd1;
	localparam logic [31:0] RUN_MAX       = 32'hFFFF_FFFF;
	localparam logic [1:0]  ADDR_MIN_RUN  = 2'd0;

	// One queued command: the work one input byte leaves for the back end
	typedef struct packed {
		logic [31:0] close_len;
		logic [31:0] tail_len;
		logic        lit_v;
		logic [7:0]  lit_byte;
		logic        last;
	} cmd_t;

	typedef struct packed {
		logic [7:0] data;
		logic       buffer_end;
		logic       step_end;
	} res_t;

	function automatic logic [4:0] eff_min(input logic [4:0] m);
		logic [4:0] r;
		r = m;
		if (m == 5'd0)
			r = 5'd1;
		else if (m > MIN_RUN_CEIL)
			r = MIN_RUN_CEIL;
		return r;
	endfunction

endpackage

// ===== hdl/zrle_fifo.sv =====
// Small synchronous FIFO built from registers, used for the command and result queues.
// Combinational read of the head entry; no dependencies.
`timescale 1ns / 1ps

module zrle_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CNTW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = push && !full;
	assign do_rd   = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + CNTW'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - CNTW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

// ===== hdl/zrle_front.sv =====
// Front end of the zero-run RLE encoder: takes input bytes, tracks the pending zero run
// and queues a command for every byte that leaves work. Depends on zrle_pkg.
`timescale 1ns / 1ps

module zrle_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [7:0]    in_byte,
	input  logic          in_last,
	output logic          cmd_push,
	output zrle_pkg::cmd_t cmd,
	input  logic          cmd_full
);

	import zrle_pkg::*;

	logic [31:0] zrc_q;
	logic        accept;
	logic        is_zero;
	logic        at_max;
	logic [31:0] run_inc;
	logic        need_cmd;

	assign full    = cmd_full;
	assign accept  = push && !cmd_full;
	assign is_zero = (in_byte == 8'd0);
	assign at_max  = (zrc_q == RUN_MAX);
	// a zero on a full-length run closes that run and starts a new one
	assign run_inc = at_max ? 32'd1 : zrc_q + 32'd1;

	always_comb begin
		cmd.close_len = is_zero ? (at_max ? RUN_MAX : 32'd0) : zrc_q;
		cmd.tail_len  = (is_zero && in_last) ? run_inc : 32'd0;
		cmd.lit_v     = !is_zero;
		cmd.lit_byte  = in_byte;
		cmd.last      = in_last;
	end

	assign need_cmd = !is_zero || at_max || in_last;
	assign cmd_push = accept && need_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zrc_q <= '0;
		end else if (accept) begin
			if (in_last || !is_zero)
				zrc_q <= '0;
			else
				zrc_q <= run_inc;
		end
	end

	a_cmd_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command pushed into a full queue");

	a_run_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_byte != 8'd0 || in_last)) |=> (zrc_q == 32'd0))
		else $error("zero run not cleared after a closing byte");

endmodule

// ===== hdl/zrle_back.sv =====
// Back end of the zero-run RLE encoder: runs queued commands, keeps the literal store and emits
// encoded bytes one per cycle while the result queue has room, marking the last byte of each item. Depends on zrle_pkg.
`timescale 1ns / 1ps

module zrle_back #(
	parameter int LIT_MAX = zrle_pkg::LITERAL_CHUNK_MAX
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [4:0]     min_run,
	input  logic           cmd_empty,
	output logic           cmd_pop,
	input  zrle_pkg::cmd_t cmd,
	input  logic           res_full,
	output logic           res_push,
	output zrle_pkg::res_t res
);

	import zrle_pkg::*;

	localparam int CW = $clog2(LIT_MAX + 1);
	localparam int IW = $clog2(LIT_MAX);
	localparam logic [2:0] HDR_LAST = 3'd4;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HDR, ST_DATA} state_t;
	typedef enum logic [1:0] {PH_CLOSE1, PH_LIT, PH_CLOSE2, PH_FLUSH} phase_t;

	state_t      state_q;
	phase_t      ph_q;
	phase_t      nxt_ph;
	logic        nxt_done;
	cmd_t        cmd_q;
	logic [31:0] run_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] lit_idx_q;
	logic [2:0]  hdr_idx_q;
	logic        hdr_lit_q;
	logic        pend_v_q;
	logic [7:0]  pend_byte_q;
	logic [7:0]  store_q [LIT_MAX];

	logic        go;
	logic [4:0]  min_eff;
	logic        run_long;
	logic        cnt_full;
	logic        close_ph;
	logic [31:0] hdr_len;
	logic [7:0]  hdr_byte;
	logic        emit;
	logic [7:0]  emit_byte;
	logic        zero_wr;
	logic        lit_wr;
	logic        st_wr;
	logic [7:0]  st_byte;
	logic        flush_go;
	logic        run_hdr_go;
	logic        adv;

	assign go       = !res_full;
	assign min_eff  = eff_min(min_run);
	assign run_long = (run_q >= {27'd0, min_eff});
	assign cnt_full = (cnt_q == CW'(LIT_MAX));
	assign close_ph = (ph_q == PH_CLOSE1) || (ph_q == PH_CLOSE2);

	assign hdr_len = hdr_lit_q ? 32'(cnt_q) : run_q;
	always_comb begin
		case (hdr_idx_q)
			3'd0:    hdr_byte = hdr_lit_q ? OP_LITERAL : OP_ZERO_RUN;
			3'd1:    hdr_byte = hdr_len[7:0];
			3'd2:    hdr_byte = hdr_len[15:8];
			3'd3:    hdr_byte = hdr_len[23:16];
			default: hdr_byte = hdr_len[31:24];
		endcase
	end

	assign emit      = (state_q == ST_HDR) || (state_q == ST_DATA);
	assign emit_byte = (state_q == ST_HDR) ? hdr_byte : store_q[lit_idx_q];

	// short run: its zeros go into the store one per cycle while the result queue has room
	assign zero_wr = (state_q == ST_RUN) && close_ph && (run_q != 32'd0) && !run_long
		&& !cnt_full;
	assign lit_wr  = (state_q == ST_RUN) && (ph_q == PH_LIT) && !cnt_full;
	assign st_wr   = go && (zero_wr || lit_wr);
	assign st_byte = lit_wr ? cmd_q.lit_byte : 8'd0;

	assign flush_go = (state_q == ST_RUN) && (
		(close_ph && (run_q != 32'd0) && ((run_long && cnt_q != '0) || (!run_long && cnt_full)))
		|| ((ph_q == PH_LIT) && cnt_full)
		|| ((ph_q == PH_FLUSH) && (cnt_q != '0)));
	assign run_hdr_go = (state_q == ST_RUN) && close_ph && (run_q != 32'd0) && run_long
		&& (cnt_q == '0);
	assign adv = (state_q == ST_RUN) && (
		(close_ph && (run_q == 32'd0))
		|| ((ph_q == PH_LIT) && !cnt_full)
		|| ((ph_q == PH_FLUSH) && (cnt_q == '0)));

	always_comb begin
		nxt_ph   = PH_FLUSH;
		nxt_done = 1'b0;
		unique case (ph_q)
			PH_CLOSE1: begin
				if (cmd_q.lit_v)
					nxt_ph = PH_LIT;
				else if (cmd_q.last)
					nxt_ph = PH_CLOSE2;
				else
					nxt_done = 1'b1;
			end
			PH_LIT: begin
				if (cmd_q.last)
					nxt_ph = PH_CLOSE2;
				else
					nxt_done = 1'b1;
			end
			PH_CLOSE2: nxt_ph = PH_FLUSH;
			PH_FLUSH:  nxt_done = 1'b1;
			default:   nxt_done = 1'b1;
		endcase
	end

	// the byte held in pend goes out once the next byte or the end of the item is known
	assign res_push       = go && pend_v_q && (emit || state_q == ST_IDLE);
	assign res.data       = pend_byte_q;
	assign res.step_end   = (state_q == ST_IDLE);
	assign res.buffer_end = (state_q == ST_IDLE) && cmd_q.last;
	assign cmd_pop        = go && (state_q == ST_IDLE) && !cmd_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ph_q        <= PH_CLOSE1;
			cmd_q       <= '0;
			run_q       <= '0;
			cnt_q       <= '0;
			lit_idx_q   <= '0;
			hdr_idx_q   <= '0;
			hdr_lit_q   <= 1'b0;
			pend_v_q    <= 1'b0;
			pend_byte_q <= '0;
		end else if (go) begin
			if (emit) begin
				pend_v_q    <= 1'b1;
				pend_byte_q <= emit_byte;
			end else if (state_q == ST_IDLE) begin
				pend_v_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (!cmd_empty) begin
						cmd_q   <= cmd;
						state_q <= ST_RUN;
						if (cmd.close_len != 32'd0) begin
							ph_q  <= PH_CLOSE1;
							run_q <= cmd.close_len;
						end else if (cmd.lit_v) begin
							ph_q  <= PH_LIT;
							run_q <= 32'd0;
						end else begin
							ph_q  <= PH_CLOSE2;
							run_q <= cmd.tail_len;
						end
					end
				end
				ST_RUN: begin
					if (flush_go) begin
						hdr_lit_q <= 1'b1;
						hdr_idx_q <= '0;
						state_q   <= ST_HDR;
					end else if (run_hdr_go) begin
						hdr_lit_q <= 1'b0;
						hdr_idx_q <= '0;
						state_q   <= ST_HDR;
					end
					if (zero_wr) begin
						cnt_q <= cnt_q + CW'(1);
						run_q <= run_q - 32'd1;
					end
					if (lit_wr)
						cnt_q <= cnt_q + CW'(1);
					if (adv) begin
						if (nxt_done) begin
							state_q <= ST_IDLE;
						end else begin
							ph_q <= nxt_ph;
							if (nxt_ph == PH_CLOSE2)
								run_q <= cmd_q.tail_len;
						end
					end
				end
				ST_HDR: begin
					if (hdr_idx_q == HDR_LAST) begin
						if (hdr_lit_q) begin
							lit_idx_q <= '0;
							state_q   <= ST_DATA;
						end else begin
							// run chunk written: the run is closed
							run_q   <= 32'd0;
							state_q <= ST_RUN;
						end
					end else begin
						hdr_idx_q <= hdr_idx_q + 3'd1;
					end
				end
				ST_DATA: begin
					if (CW'(lit_idx_q) + CW'(1) == cnt_q) begin
						cnt_q   <= '0;
						state_q <= ST_RUN;
					end else begin
						lit_idx_q <= lit_idx_q + IW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_wr)
			store_q[cnt_q[IW-1:0]] <= st_byte;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(LIT_MAX))
		else $error("literal count beyond chunk maximum");

	a_data_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DATA) |-> (cnt_q != '0))
		else $error("literal data phase with an empty store");

	a_end_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && pend_v_q && go) |=> !pend_v_q)
		else $error("held byte not released at end of item");

	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

endmodule

// ===== hdl/zero_run_rle_encoder_unit.sv =====
// Zero-run RLE encoder, top level: configuration register, front end, command queue,
// back end and result queue. Depends on zrle_pkg, zrle_fifo, zrle_front, zrle_back.
//
// Use: push raw bytes on in_byte with in_last on the final byte of a buffer; a byte is
// taken at a clock edge with push high and full low. Encoded bytes come out on out_byte
// while empty is low and are taken at an edge with pop high. out_step_end marks the last
// byte released by one input byte, out_buffer_end the final byte of the buffer.
// The run threshold register sits at byte address 0 of the APB port (reset 8; 0 acts as 1,
// above 16 as 16); write it only while the encoder is idle.
// Throughput: the front takes one byte a cycle while the command queue has room; a byte that
// leaves no work (a zero inside a run) queues no command. The back sequencer starts each item,
// stores each literal and each zero of a short run, leaves each run-closing or flush phase,
// launches each chunk and then emits its encoded bytes. Encoded bytes pass through the command
// queue, the back end's held byte and the result queue before they reach the ports.
// Reset clears the run and literal counts and both queues. If the receiver stalls, the
// four-deep result queue fills, the back end holds, the two-deep command queue fills and
// full rises; nothing is dropped.
`timescale 1ns / 1ps

module zero_run_rle_encoder_unit #(
	parameter int LIT_MAX = zrle_pkg::LITERAL_CHUNK_MAX
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        out_buffer_end,
	output logic        out_step_end
);

	import zrle_pkg::*;

	logic [4:0] min_run_q;
	logic       cmd_push;
	cmd_t       cmd_w;
	logic       cmd_full;
	logic       cmd_pop;
	cmd_t       cmd_r;
	logic       cmd_empty;
	logic       res_push;
	res_t       res_w;
	logic       res_full;
	res_t       res_r;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_MIN_RUN) ? {27'd0, min_run_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			min_run_q <= MIN_RUN_RESET;
		else if (psel && penable && pwrite && pready && paddr == ADDR_MIN_RUN)
			min_run_q <= pwdata[4:0];
	end

	zrle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.cmd_push (cmd_push),
		.cmd      (cmd_w),
		.cmd_full (cmd_full)
	);

	zrle_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_FIFO_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.wr_data (cmd_w),
		.full    (cmd_full),
		.pop     (cmd_pop),
		.rd_data (cmd_r),
		.empty   (cmd_empty)
	);

	zrle_back #(
		.LIT_MAX (LIT_MAX)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.min_run   (min_run_q),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd_r),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_w)
	);

	zrle_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (RES_FIFO_DEPTH)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_w),
		.full    (res_full),
		.pop     (pop),
		.rd_data (res_r),
		.empty   (empty)
	);

	assign out_byte       = res_r.data;
	assign out_buffer_end = res_r.buffer_end;
	assign out_step_end   = res_r.step_end;

endmodule
